FILE: rtl/cidq_pkg.sv
// Shared types and constants for the counting debouncer with event queue.
package cidq_pkg;

	localparam int unsigned COUNT_W  = 16;
	localparam int unsigned PINS_W   = 16;
	localparam logic [COUNT_W-1:0] COUNT_MAX = 16'hffff;

	// item modes
	localparam logic [1:0] MODE_TICK  = 2'd0;
	localparam logic [1:0] MODE_POP   = 2'd1;
	localparam logic [1:0] MODE_FLUSH = 2'd2;

	// config register indexes
	localparam logic [3:0] REG_SAMPLE_PERIOD   = 4'd0;
	localparam logic [3:0] REG_CLASSIFY_PERIOD = 4'd1;
	localparam logic [3:0] REG_ACTIVE_THRESH   = 4'd2;
	localparam logic [3:0] REG_INPUTS_USED     = 4'd3;

	// message codes, top two bits of a ring entry
	localparam logic [1:0] CODE_UP   = 2'b01;
	localparam logic [1:0] CODE_DOWN = 2'b10;

	typedef struct packed {
		logic [1:0]        mode;
		logic [PINS_W-1:0] pin_levels;
	} item_t;

	typedef struct packed {
		logic              msg_valid;
		logic [3:0]        msg_input;
		logic              msg_rising;
		logic [PINS_W-1:0] input_states;
	} result_t;

	typedef struct packed {
		logic [COUNT_W-1:0] sample_period;
		logic [COUNT_W-1:0] classify_period;
		logic [COUNT_W-1:0] active_threshold;
		logic [4:0]         inputs_used;
	} cfg_t;

	// work request handed from front to back
	typedef struct packed {
		logic [1:0]        mode;
		logic [PINS_W-1:0] pin_levels;
		logic              do_sample;
		logic              do_classify;
	} cmd_t;

	typedef struct packed {
		logic [7:0] wr_ptr;
		logic [7:0] rd_ptr;
	} ring_stat_t;

endpackage

FILE: rtl/cidq_ram.sv
// Generic single-write, single-read RAM with registered read data.
module cidq_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

FILE: rtl/cidq_fifo.sv
// Small register FIFO used for the request and result queues.
module cidq_fifo #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  logic [WIDTH-1:0] wr_data,
	output logic             full,
	input  logic             rd_en,
	output logic [WIDTH-1:0] rd_data,
	output logic             empty
);

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] data_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_wr;
	logic             do_rd;

	assign full    = (count_q == CNT_W'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_data = data_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + CNT_W'(1);
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) begin
			data_q[wr_ptr_q] <= wr_data;
		end
	end

endmodule

FILE: rtl/cidq_front.sv
// Front end: accepts items, runs the sample and classify timers, emits requests.
module cidq_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  cidq_pkg::item_t    item,
	input  cidq_pkg::cfg_t     cfg,
	input  logic               cmd_full,
	output logic               cmd_wr,
	output cidq_pkg::cmd_t     cmd
);

	logic [cidq_pkg::COUNT_W-1:0] smp_tmr_q;
	logic [cidq_pkg::COUNT_W-1:0] cls_tmr_q;
	logic [cidq_pkg::COUNT_W-1:0] smp_nxt;
	logic [cidq_pkg::COUNT_W-1:0] cls_nxt;
	logic [cidq_pkg::COUNT_W-1:0] smp_per;
	logic [cidq_pkg::COUNT_W-1:0] cls_per;
	logic                         is_tick;
	logic                         smp_hit;
	logic                         cls_hit;

	// period of zero behaves as one
	assign smp_per = (cfg.sample_period == '0) ? 16'd1 : cfg.sample_period;
	assign cls_per = (cfg.classify_period == '0) ? 16'd1 : cfg.classify_period;
	assign smp_nxt = smp_tmr_q + 16'd1;
	assign cls_nxt = cls_tmr_q + 16'd1;
	assign smp_hit = (smp_nxt >= smp_per);
	assign cls_hit = (cls_nxt >= cls_per);

	assign cmd_wr  = push && !cmd_full;
	assign is_tick = (item.mode == cidq_pkg::MODE_TICK);

	always_comb begin
		cmd.mode        = item.mode;
		cmd.pin_levels  = item.pin_levels;
		cmd.do_sample   = is_tick && smp_hit;
		cmd.do_classify = is_tick && cls_hit;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			smp_tmr_q <= '0;
			cls_tmr_q <= '0;
		end else if (cmd_wr && is_tick) begin
			smp_tmr_q <= smp_hit ? '0 : smp_nxt;
			cls_tmr_q <= cls_hit ? '0 : cls_nxt;
		end
	end

endmodule

FILE: rtl/cidq_back.sv
// Back end: high counts, qualified levels, message ring and result assembly.
module cidq_back #(
	parameter int unsigned NUM_INPUTS = 16,
	parameter int unsigned RING_DEPTH = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  cidq_pkg::cfg_t       cfg,
	input  cidq_pkg::cmd_t       cmd,
	input  logic                 cmd_empty,
	output logic                 cmd_rd,
	input  logic                 res_full,
	output logic                 res_wr,
	output cidq_pkg::result_t    res,
	output cidq_pkg::ring_stat_t stat
);

	localparam int unsigned IDX_W = (NUM_INPUTS > 1) ? $clog2(NUM_INPUTS) : 1;
	localparam int unsigned CNT_W = $clog2(NUM_INPUTS + 1);
	localparam int unsigned PTR_W = $clog2(RING_DEPTH);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CLASSIFY,
		ST_POP_RD,
		ST_DONE
	} state_t;

	state_t                       state_q;
	logic [cidq_pkg::COUNT_W-1:0] counts_q [NUM_INPUTS];
	logic [NUM_INPUTS-1:0]        qual_q;
	logic [PTR_W-1:0]             wp_q;
	logic [PTR_W-1:0]             rp_q;
	logic [IDX_W-1:0]             cls_i_q;
	logic                         msg_valid_q;
	logic [3:0]                   msg_input_q;
	logic                         msg_rising_q;

	logic [CNT_W-1:0]             n_used;
	logic [63:0]                  lv;
	logic                         smp_en;
	logic                         cls_run;
	logic                         act;
	logic                         chg;
	logic                         last;
	logic [PTR_W-1:0]             wp_nxt;
	logic [PTR_W-1:0]             rp_nxt;
	logic                         ring_ne;
	logic                         ram_we;
	logic                         ram_re;
	logic [7:0]                   ram_wdata;
	logic [7:0]                   ram_rdata;
	logic [cidq_pkg::PINS_W-1:0]  states;

	assign n_used = ({27'd0, cfg.inputs_used} > NUM_INPUTS) ? CNT_W'(NUM_INPUTS)
		: CNT_W'(cfg.inputs_used);
	assign lv      = 64'(cmd.pin_levels);
	assign cmd_rd  = (state_q == ST_IDLE) && !cmd_empty;
	assign smp_en  = cmd_rd && (cmd.mode == cidq_pkg::MODE_TICK) && cmd.do_sample;
	assign cls_run = (state_q == ST_CLASSIFY);
	assign act     = (counts_q[cls_i_q] >= cfg.active_threshold);
	assign chg     = (act != qual_q[cls_i_q]);
	assign last    = ((CNT_W'(cls_i_q) + CNT_W'(1)) == n_used);
	assign wp_nxt  = (wp_q == PTR_W'(RING_DEPTH - 1)) ? '0 : wp_q + PTR_W'(1);
	assign rp_nxt  = (rp_q == PTR_W'(RING_DEPTH - 1)) ? '0 : rp_q + PTR_W'(1);
	assign ring_ne = (wp_q != rp_q);

	assign ram_we    = cls_run && chg;
	assign ram_wdata = {act ? cidq_pkg::CODE_UP : cidq_pkg::CODE_DOWN, 6'(cls_i_q)};
	assign ram_re    = cmd_rd && (cmd.mode == cidq_pkg::MODE_POP) && ring_ne;

	cidq_ram #(
		.WIDTH(8),
		.DEPTH(RING_DEPTH)
	) u_ring (
		.clk  (clk),
		.we   (ram_we),
		.waddr(wp_q),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(rp_q),
		.rdata(ram_rdata)
	);

	// reported levels: inputs past the number in use read 0
	for (genvar g = 0; g < cidq_pkg::PINS_W; g++) begin : g_states
		if (g < NUM_INPUTS) begin : g_used
			assign states[g] = qual_q[g] && (CNT_W'(g) < n_used);
		end else begin : g_unused
			assign states[g] = 1'b0;
		end
	end

	assign res_wr = (state_q == ST_DONE) && !res_full;
	always_comb begin
		res.msg_valid    = msg_valid_q;
		res.msg_input    = msg_input_q;
		res.msg_rising   = msg_rising_q;
		res.input_states = states;
	end

	assign stat.wr_ptr = 8'(wp_q);
	assign stat.rd_ptr = 8'(rp_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			qual_q       <= '1;
			wp_q         <= '0;
			rp_q         <= '0;
			cls_i_q      <= '0;
			msg_valid_q  <= 1'b0;
			msg_input_q  <= '0;
			msg_rising_q <= 1'b0;
			for (int l = 0; l < NUM_INPUTS; l++) begin
				counts_q[l] <= '0;
			end
		end else begin
			// sampling happens on request pickup, clearing during the classify walk
			for (int l = 0; l < NUM_INPUTS; l++) begin
				if (smp_en && (CNT_W'(l) < n_used) && lv[l]
						&& (counts_q[l] != cidq_pkg::COUNT_MAX)) begin
					counts_q[l] <= counts_q[l] + 16'd1;
				end else if (cls_run && (cls_i_q == IDX_W'(l))) begin
					counts_q[l] <= '0;
				end
			end

			case (state_q)
				ST_IDLE: begin
					if (cmd_rd) begin
						msg_valid_q  <= 1'b0;
						msg_input_q  <= '0;
						msg_rising_q <= 1'b0;
						cls_i_q      <= '0;
						case (cmd.mode)
							cidq_pkg::MODE_TICK: begin
								if (cmd.do_classify && (n_used != '0)) begin
									state_q <= ST_CLASSIFY;
								end else begin
									state_q <= ST_DONE;
								end
							end
							cidq_pkg::MODE_POP: begin
								if (ring_ne) begin
									rp_q    <= rp_nxt;
									state_q <= ST_POP_RD;
								end else begin
									state_q <= ST_DONE;
								end
							end
							cidq_pkg::MODE_FLUSH: begin
								wp_q    <= '0;
								rp_q    <= '0;
								state_q <= ST_DONE;
							end
							default: begin
								state_q <= ST_DONE;
							end
						endcase
					end
				end
				ST_CLASSIFY: begin
					if (chg) begin
						qual_q[cls_i_q] <= act;
						wp_q            <= wp_nxt;
						// ring full: drop the oldest message
						if (wp_nxt == rp_q) begin
							rp_q <= rp_nxt;
						end
					end
					if (last) begin
						state_q <= ST_DONE;
					end else begin
						cls_i_q <= cls_i_q + IDX_W'(1);
					end
				end
				ST_POP_RD: begin
					msg_valid_q  <= 1'b1;
					msg_input_q  <= ram_rdata[3:0];
					msg_rising_q <= (ram_rdata[7:6] == cidq_pkg::CODE_UP);
					state_q      <= ST_DONE;
				end
				ST_DONE: begin
					if (!res_full) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

FILE: rtl/counting_input_debouncer_event_queue.sv
// A tick without classification, a flush or an empty pop goes straight to the done state,
// a pop with a message reads the ring first, a classifying tick walks the n inputs in use
// (one input per cycle) before the done state.
// Throughput: one request at a time in the back end; the classify walk sets the worst case.
// Reset: counts zero, qualified levels all ones, ring pointers and timers zero,
// registers at their defaults; ring contents are not cleared.
module counting_input_debouncer_event_queue #(
	parameter int unsigned NUM_INPUTS = 16,
	parameter int unsigned RING_DEPTH = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	output logic              full,
	input  cidq_pkg::item_t   item,
	output logic              empty,
	input  logic              pop,
	output cidq_pkg::result_t result,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [3:0]        cfg_index,
	input  logic [15:0]       cfg_data
);

	localparam int unsigned CMD_W = $bits(cidq_pkg::cmd_t);
	localparam int unsigned RES_W = $bits(cidq_pkg::result_t);

	cidq_pkg::cfg_t       cfg_q;
	cidq_pkg::cmd_t       cmd_in;
	cidq_pkg::cmd_t       cmd_out;
	cidq_pkg::result_t    res_in;
	cidq_pkg::ring_stat_t ring_stat;
	logic [CMD_W-1:0]     cmd_rd_data;
	logic [RES_W-1:0]     res_rd_data;
	logic                 cmd_wr;
	logic                 cmd_rd;
	logic                 cmd_empty;
	logic                 res_wr;
	logic                 res_full;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.sample_period    <= 16'd1;
			cfg_q.classify_period  <= 16'd100;
			cfg_q.active_threshold <= 16'd50;
			cfg_q.inputs_used      <= 5'd16;
		end else if (cfg_valid) begin
			case (cfg_index)
				cidq_pkg::REG_SAMPLE_PERIOD:   cfg_q.sample_period    <= cfg_data;
				cidq_pkg::REG_CLASSIFY_PERIOD: cfg_q.classify_period  <= cfg_data;
				cidq_pkg::REG_ACTIVE_THRESH:   cfg_q.active_threshold <= cfg_data;
				cidq_pkg::REG_INPUTS_USED:     cfg_q.inputs_used      <= cfg_data[4:0];
				default: begin
				end
			endcase
		end
	end

	cidq_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.item    (item),
		.cfg     (cfg_q),
		.cmd_full(full),
		.cmd_wr  (cmd_wr),
		.cmd     (cmd_in)
	);

	cidq_fifo #(
		.WIDTH(CMD_W),
		.DEPTH(2)
	) u_cmd_q (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (cmd_wr),
		.wr_data(cmd_in),
		.full   (full),
		.rd_en  (cmd_rd),
		.rd_data(cmd_rd_data),
		.empty  (cmd_empty)
	);

	assign cmd_out = cidq_pkg::cmd_t'(cmd_rd_data);

	cidq_back #(
		.NUM_INPUTS(NUM_INPUTS),
		.RING_DEPTH(RING_DEPTH)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.cmd      (cmd_out),
		.cmd_empty(cmd_empty),
		.cmd_rd   (cmd_rd),
		.res_full (res_full),
		.res_wr   (res_wr),
		.res      (res_in),
		.stat     (ring_stat)
	);

	cidq_fifo #(
		.WIDTH(RES_W),
		.DEPTH(2)
	) u_res_q (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (res_wr),
		.wr_data(res_in),
		.full   (res_full),
		.rd_en  (pop),
		.rd_data(res_rd_data),
		.empty  (empty)
	);

	assign result = cidq_pkg::result_t'(res_rd_data);

	// ring pointers wrap at the ring depth, which need not be a power of two
	a_ptr_range: assert property (@(posedge clk) disable iff (!arst_n)
		(ring_stat.wr_ptr < RING_DEPTH) && (ring_stat.rd_ptr < RING_DEPTH))
		else $error("ring pointer out of range");

	a_res_space: assert property (@(posedge clk) disable iff (!arst_n)
		res_wr |-> !res_full)
		else $error("result written into full result queue");

	a_cmd_avail: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_rd |-> !cmd_empty)
		else $error("request taken from empty queue");

	// a flush leaves the ring empty once it is done
	a_flush_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd_rd && (cmd_out.mode == cidq_pkg::MODE_FLUSH)) |=>
		(ring_stat.wr_ptr == 8'd0) && (ring_stat.rd_ptr == 8'd0))
		else $error("ring not empty after flush");

endmodule

FILE: tb/tb_top.sv
// Self-checking testbench for the counting debouncer with event queue.
`timescale 1ns / 100ps

class debounce_scoreboard;
	localparam int NUM_PINS = 16;
	localparam int RING_SLOTS = 32;

	logic [15:0] sample_period;
	logic [15:0] classify_period;
	logic [15:0] active_threshold;
	logic [4:0]  inputs_used;

	logic [15:0] high_count [NUM_PINS];
	bit          qualified [NUM_PINS];
	logic [7:0]  ring [RING_SLOTS];
	int unsigned wr_ptr;
	int unsigned rd_ptr;
	logic [15:0] sample_tmr;
	logic [15:0] classify_tmr;

	cidq_pkg::result_t expected_reports [$];
	int mismatches;

	function new();
		sample_period = 16'd1;
		classify_period = 16'd100;
		active_threshold = 16'd50;
		inputs_used = 5'd16;
		foreach (high_count[i]) begin
			high_count[i] = '0;
			qualified[i] = 1'b1;
		end
		wr_ptr = 0;
		rd_ptr = 0;
		sample_tmr = '0;
		classify_tmr = '0;
		mismatches = 0;
	endfunction

	function void write_reg(logic [3:0] idx, logic [15:0] data);
		case (idx)
			cidq_pkg::REG_SAMPLE_PERIOD: sample_period = data;
			cidq_pkg::REG_CLASSIFY_PERIOD: classify_period = data;
			cidq_pkg::REG_ACTIVE_THRESH: active_threshold = data;
			cidq_pkg::REG_INPUTS_USED: inputs_used = data[4:0];
			default: ;
		endcase
	endfunction

	function int pending();
		return expected_reports.size();
	endfunction

	function int unsigned pins_in_use();
		return (inputs_used > NUM_PINS) ? NUM_PINS : inputs_used;
	endfunction

	// period 0 behaves as 1; timer restarts on the tick that reaches the period
	function bit timer_elapses(inout logic [15:0] t, input logic [15:0] period);
		logic [15:0] p;
		p = (period == 16'd0) ? 16'd1 : period;
		t = t + 16'd1;
		if (t >= p) begin
			t = '0;
			return 1'b1;
		end
		return 1'b0;
	endfunction

	// full ring drops the oldest message
	function void push_message(int unsigned idx, logic [1:0] code);
		ring[wr_ptr] = {code, 6'(idx)};
		wr_ptr = (wr_ptr + 1) % RING_SLOTS;
		if (wr_ptr == rd_ptr)
			rd_ptr = (rd_ptr + 1) % RING_SLOTS;
	endfunction

	function void tick(logic [15:0] pins);
		int unsigned n;
		bit do_sample;
		bit do_classify;
		bit act;
		n = pins_in_use();
		do_sample = timer_elapses(sample_tmr, sample_period);
		do_classify = timer_elapses(classify_tmr, classify_period);
		if (do_sample) begin
			for (int i = 0; i < n; i++)
				if (pins[i] && high_count[i] != 16'hffff)
					high_count[i] = high_count[i] + 16'd1;
		end
		if (do_classify) begin
			for (int i = 0; i < n; i++) begin
				act = (high_count[i] >= active_threshold);
				if (act != qualified[i]) begin
					push_message(i, act ? cidq_pkg::CODE_UP : cidq_pkg::CODE_DOWN);
					qualified[i] = act;
				end
				high_count[i] = '0;
			end
		end
	endfunction

	function void note_request(cidq_pkg::item_t it);
		cidq_pkg::result_t r;
		logic [7:0] m;
		int unsigned n;
		r = '0;
		case (it.mode)
			cidq_pkg::MODE_TICK: tick(it.pin_levels);
			cidq_pkg::MODE_POP: begin
				if (wr_ptr != rd_ptr) begin
					m = ring[rd_ptr];
					rd_ptr = (rd_ptr + 1) % RING_SLOTS;
					r.msg_valid = 1'b1;
					r.msg_input = m[3:0];
					r.msg_rising = (m[7:6] == cidq_pkg::CODE_UP);
				end
			end
			cidq_pkg::MODE_FLUSH: begin
				wr_ptr = 0;
				rd_ptr = 0;
			end
			default: ;
		endcase
		n = pins_in_use();
		for (int i = 0; i < n; i++)
			r.input_states[i] = qualified[i];
		expected_reports.push_back(r);
	endfunction

	function void check_report(cidq_pkg::result_t got);
		cidq_pkg::result_t want;
		if (expected_reports.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("%0t: unexpected result valid=%b idx=%0d rise=%b states=%h",
					$realtime, got.msg_valid, got.msg_input, got.msg_rising,
					got.input_states);
			return;
		end
		want = expected_reports.pop_front();
		if (got.msg_valid !== want.msg_valid || got.msg_input !== want.msg_input ||
				got.msg_rising !== want.msg_rising ||
				got.input_states !== want.input_states) begin
			mismatches++;
			if (mismatches <= 10) begin
				$display("%0t: mismatch exp valid=%b idx=%0d rise=%b states=%h",
					$realtime, want.msg_valid, want.msg_input, want.msg_rising,
					want.input_states);
				$display("    got valid=%b idx=%0d rise=%b states=%h",
					got.msg_valid, got.msg_input, got.msg_rising, got.input_states);
			end
		end
	endfunction
endclass

module tb_top;
	localparam logic [1:0] MODE_NONE  = 2'd3;
	localparam logic [3:0] REG_UNUSED = 4'd12;
	localparam int CYCLE_LIMIT   = 300000;
	localparam int HOLD_CYCLES   = 600;
	localparam int SETTLE_CYCLES = 24;
	localparam int DRAIN_CYCLES  = 40;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              push = 1'b0;
	logic              full;
	cidq_pkg::item_t   item = '0;
	logic              empty;
	logic              pop = 1'b0;
	cidq_pkg::result_t result;
	logic              cfg_valid = 1'b0;
	logic              cfg_ready;
	logic [3:0]        cfg_index = '0;
	logic [15:0]       cfg_data = '0;

	debounce_scoreboard sb;
	int          cycle_count = 0;
	int          burst_left = 0;
	bit          sender_busy = 1'b0;
	int          rx_style = 0;
	bit          hold_request = 1'b0;
	int          hold_left = 0;
	logic [15:0] last_pins = '0;

	counting_input_debouncer_event_queue DUT (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.item(item),
		.empty(empty),
		.pop(pop),
		.result(result),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// result side: check accepted results, then pick next pop level
	always @(posedge clk) begin
		if (arst_n && pop && !empty)
			sb.check_report(result);
		if (hold_left > 0) begin
			hold_left--;
			pop <= 1'b0;
		end else if (hold_request) begin
			hold_request = 1'b0;
			hold_left = HOLD_CYCLES;
			pop <= 1'b0;
		end else begin
			case (rx_style)
				0: pop <= 1'b1;
				1: pop <= 1'($urandom_range(0, 1));
				2: pop <= (cycle_count % 7) < 4;
				default: pop <= ($urandom_range(0, 9) != 0);
			endcase
		end
	end

	function automatic cidq_pkg::item_t make_item(logic [1:0] mode, logic [15:0] pins);
		cidq_pkg::item_t it;
		it.mode = mode;
		it.pin_levels = pins;
		return it;
	endfunction

	function automatic cidq_pkg::item_t random_item();
		cidq_pkg::item_t it;
		int unsigned pick;
		pick = $urandom_range(0, 99);
		if (pick < 55)
			it.mode = cidq_pkg::MODE_TICK;
		else if (pick < 90)
			it.mode = cidq_pkg::MODE_POP;
		else if (pick < 94)
			it.mode = cidq_pkg::MODE_FLUSH;
		else
			it.mode = MODE_NONE;
		// repeating the last pattern lets counts build up toward the threshold
		pick = $urandom_range(0, 99);
		if (pick < 30)
			it.pin_levels = last_pins;
		else if (pick < 42)
			it.pin_levels = '1;
		else if (pick < 54)
			it.pin_levels = '0;
		else
			it.pin_levels = 16'($urandom);
		last_pins = it.pin_levels;
		return it;
	endfunction

	function automatic cidq_pkg::cfg_t random_config();
		cidq_pkg::cfg_t c;
		c.sample_period = 16'($urandom_range(1, 3));
		c.classify_period = 16'($urandom_range(1, 12));
		c.active_threshold = 16'($urandom_range(0, 8));
		c.inputs_used = ($urandom_range(0, 2) == 0) ? 5'($urandom) : 5'd16;
		return c;
	endfunction

	task automatic send_item(cidq_pkg::item_t it);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 20);
			gap = (sender_busy || $urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
			if (gap > 0) begin
				push <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		push <= 1'b1;
		item <= it;
		do @(posedge clk); while (full);
		sb.note_request(it);
	endtask

	task automatic write_reg(logic [3:0] idx, logic [15:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		sb.write_reg(idx, data);
	endtask

	task automatic program_regs(cidq_pkg::cfg_t c, bit with_spare);
		write_reg(cidq_pkg::REG_SAMPLE_PERIOD, c.sample_period);
		write_reg(cidq_pkg::REG_CLASSIFY_PERIOD, c.classify_period);
		write_reg(cidq_pkg::REG_ACTIVE_THRESH, c.active_threshold);
		// upper data bits are ignored by the 5-bit register
		write_reg(cidq_pkg::REG_INPUTS_USED, {11'($urandom), c.inputs_used});
		if (with_spare)
			write_reg(REG_UNUSED, 16'($urandom));
		cfg_valid <= 1'b0;
	endtask

	task automatic settle();
		push <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	initial begin
		cidq_pkg::cfg_t fixed_cfgs [5];
		cidq_pkg::cfg_t c;
		int n;
		sb = new();
		fixed_cfgs[0] = '{16'd0, 16'd0, 16'd0, 5'd0};
		fixed_cfgs[1] = '{16'hffff, 16'hffff, 16'hffff, 5'd31};
		fixed_cfgs[2] = '{16'd2, 16'd5, 16'd2, 5'd8};
		fixed_cfgs[3] = '{16'd1, 16'd3, 16'hffff, 5'd1};
		fixed_cfgs[4] = '{16'd1, 16'hffff, 16'd0, 5'd17};

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// defaults: pop on empty ring, unused mode, flush, plain ticks
		send_item(make_item(cidq_pkg::MODE_POP, 16'hffff));
		send_item(make_item(MODE_NONE, 16'hffff));
		send_item(make_item(cidq_pkg::MODE_FLUSH, 16'h1234));
		send_item(make_item(cidq_pkg::MODE_TICK, 16'hffff));
		send_item(make_item(cidq_pkg::MODE_TICK, 16'h0000));

		// classify every tick: each level swing flips all inputs, ring overflows
		settle();
		program_regs('{16'd1, 16'd1, 16'd1, 5'd16}, 1'b1);
		send_item(make_item(cidq_pkg::MODE_TICK, 16'h0000));
		send_item(make_item(cidq_pkg::MODE_POP, 16'h0000));
		send_item(make_item(cidq_pkg::MODE_POP, 16'hffff));
		send_item(make_item(cidq_pkg::MODE_TICK, 16'hffff));
		send_item(make_item(cidq_pkg::MODE_TICK, 16'h0000));
		send_item(make_item(cidq_pkg::MODE_TICK, 16'h5555));
		send_item(make_item(cidq_pkg::MODE_TICK, 16'haaaa));
		repeat (4) send_item(make_item(cidq_pkg::MODE_POP, 16'($urandom)));
		send_item(make_item(cidq_pkg::MODE_FLUSH, 16'hffff));
		send_item(make_item(cidq_pkg::MODE_POP, 16'h0000));
		send_item(make_item(cidq_pkg::MODE_TICK, 16'hffff));
		send_item(make_item(MODE_NONE, 16'h0000));
		send_item(make_item(cidq_pkg::MODE_POP, 16'h0000));
		send_item(make_item(cidq_pkg::MODE_POP, 16'h0000));

		for (int k = 0; k < 11; k++) begin
			settle();
			if (k < 5)
				c = fixed_cfgs[k];
			else if (k == 5)
				c = '{16'd1, 16'd2, 16'd1, 5'd16};
			else
				c = random_config();
			program_regs(c, 1'b0);
			rx_style = $urandom_range(0, 3);
			sender_busy = ($urandom_range(0, 3) == 0);
			n = 35;
			// receiver holds off while requests keep coming, so the block backs up
			if (k == 5) begin
				hold_request = 1'b1;
				sender_busy = 1'b1;
				n = 80;
			end
			repeat (n) send_item(random_item());
		end

		push <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.mismatches == 0 && sb.pending() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end
endmodule

FILE: files.f
rtl/cidq_pkg.sv
rtl/cidq_ram.sv
rtl/cidq_fifo.sv
rtl/cidq_front.sv
rtl/cidq_back.sv
rtl/counting_input_debouncer_event_queue.sv
tb/tb_top.sv
